### rtl/i2a_pkg.sv
// Shared types, constants and character codes of the integer to ASCII converter.
`timescale 1ns / 1ps

package i2a_pkg;

	// Low bits of the operand that take part in 64-bit mode (32 to 64).
	localparam int VALUE_WIDTH = 64;
	localparam int SHORT_WIDTH = 32;
	localparam int OPERAND_W   = 64;

	// Decimal digits that VALUE_WIDTH bits can need: floor(W * log10(2)) + 1.
	localparam int BCD_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_W      = 4 * BCD_DIGITS;

	// Digit buffer: 32 binary digits of a 32-bit value is the longest run.
	localparam int NDIG   = 32;
	localparam int IDX_W  = $clog2(NDIG);
	localparam int PAD_W  = 4 * NDIG;
	localparam int STEP_W = $clog2(VALUE_WIDTH + 1);

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] MODE_S32 = 2'd0;
	localparam logic [1:0] MODE_U32 = 2'd1;

	localparam logic [1:0] RADIX_BIN = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_DEC = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_B     = 8'h62;

	typedef struct packed {
		logic [OPERAND_W-1:0] value;
		logic [1:0]           width_mode;
		logic [1:0]           radix_code;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last;
		logic       error;
	} out_item_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic                   err;
		logic                   neg;
		logic                   wide;
		logic [1:0]             radix_code;
		logic [VALUE_WIDTH-1:0] mag;
	} desc_t;

endpackage

### rtl/i2a_front.sv
// Front end: classifies a request and forms the magnitude to convert.
`timescale 1ns / 1ps

module i2a_front (
	input  i2a_pkg::in_item_t operand,
	output i2a_pkg::desc_t    desc
);
	import i2a_pkg::*;

	logic                   neg;
	logic                   wide;
	logic [SHORT_WIDTH-1:0] low_word;
	logic [SHORT_WIDTH-1:0] mag_short;

	assign low_word  = operand.value[SHORT_WIDTH-1:0];
	assign neg       = (operand.width_mode == MODE_S32) && low_word[SHORT_WIDTH-1];
	// Two's complement negate in 32 bits: the most negative value stays 2^31.
	assign mag_short = neg ? (~low_word + 1'b1) : low_word;
	assign wide      = (operand.width_mode != MODE_S32) && (operand.width_mode != MODE_U32);

	always_comb begin
		desc.err        = wide && (operand.radix_code == RADIX_BIN);
		desc.neg        = neg;
		desc.wide       = wide;
		desc.radix_code = operand.radix_code;
		if (wide) begin
			desc.mag = operand.value[VALUE_WIDTH-1:0];
		end else begin
			desc.mag = {{(VALUE_WIDTH-SHORT_WIDTH){1'b0}}, mag_short};
		end
	end

endmodule

### rtl/i2a_fifo.sv
// Short queue of classified requests between the front and the back.
`timescale 1ns / 1ps

module i2a_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  i2a_pkg::desc_t wdata,
	output logic           full,
	input  logic           pop,
	output i2a_pkg::desc_t rdata,
	output logic           empty
);
	import i2a_pkg::*;

	desc_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/i2a_back.sv
// Back end: digit extraction (shift-add-3 for decimal) and character emission.
`timescale 1ns / 1ps

module i2a_back (
	input  logic               clk,
	input  logic               arst_n,
	input  i2a_pkg::desc_t     desc,
	input  logic               desc_empty,
	output logic               desc_pop,
	output i2a_pkg::out_item_t result,
	output logic               empty,
	input  logic               pop
);
	import i2a_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]             state_q;
	desc_t                  cur_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [VALUE_WIDTH-1:0] sh_q;
	logic [STEP_W-1:0]      cnt_q;
	logic [3:0]             dig_q [NDIG];
	logic [IDX_W-1:0]       idx_q;
	logic                   sign_q;
	logic                   zero_q;
	logic                   x_q;
	logic                   dig_act_q;
	out_item_t              out_q;
	logic                   out_vld_q;

	logic [BCD_W-1:0]       bcd_adj;
	logic [PAD_W-1:0]       bin_pad;
	logic [PAD_W-1:0]       bcd_pad;
	logic [3:0]             nib [NDIG];
	logic [IDX_W-1:0]       top;
	logic                   slot_free;
	logic                   emit;
	logic [3:0]             cur_dig;
	logic [7:0]             dig_char;
	out_item_t              nxt;
	logic                   done;

	assign desc_pop  = (state_q == ST_IDLE) && !desc_empty;
	assign slot_free = !out_vld_q || pop;
	assign emit      = (state_q == ST_EMIT) && slot_free;
	assign result    = out_q;
	assign empty     = !out_vld_q;

	// Add 3 to every BCD digit of 5 or more ahead of the shift.
	always_comb begin
		for (int j = 0; j < BCD_DIGITS; j++) begin
			if (bcd_q[4*j +: 4] >= 4'd5) begin
				bcd_adj[4*j +: 4] = bcd_q[4*j +: 4] + 4'd3;
			end else begin
				bcd_adj[4*j +: 4] = bcd_q[4*j +: 4];
			end
		end
	end

	assign bin_pad = {{(PAD_W-VALUE_WIDTH){1'b0}}, sh_q};
	assign bcd_pad = {{(PAD_W-BCD_W){1'b0}}, bcd_q};

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			unique case (cur_q.radix_code)
				RADIX_BIN: nib[i] = {3'b000, bin_pad[i]};
				RADIX_OCT: nib[i] = {1'b0, bin_pad[3*i +: 3]};
				RADIX_DEC: nib[i] = bcd_pad[4*i +: 4];
				RADIX_HEX: nib[i] = bin_pad[4*i +: 4];
				default:   nib[i] = 4'd0;
			endcase
		end
	end

	// Highest nonzero digit; zero still prints one digit.
	always_comb begin
		top = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (nib[i] != 4'd0) begin
				top = IDX_W'(i);
			end
		end
	end

	assign cur_dig  = dig_q[idx_q];
	assign dig_char = (cur_dig >= 4'd10) ? ({4'b0000, cur_dig} - 8'd10 + CH_UPPER)
	                                     : ({4'b0000, cur_dig} + CH_ZERO);

	always_comb begin
		nxt.char_out = CH_NUL;
		nxt.last     = 1'b0;
		nxt.error    = 1'b0;
		done         = 1'b0;
		priority if (cur_q.err) begin
			nxt.last  = 1'b1;
			nxt.error = 1'b1;
			done      = 1'b1;
		end else if (sign_q) begin
			nxt.char_out = CH_MINUS;
		end else if (zero_q) begin
			nxt.char_out = CH_ZERO;
		end else if (x_q) begin
			nxt.char_out = CH_X;
		end else if (dig_act_q) begin
			nxt.char_out = dig_char;
			nxt.last     = (idx_q == '0) && (cur_q.radix_code != RADIX_BIN);
			done         = nxt.last;
		end else begin
			nxt.char_out = CH_B;
			nxt.last     = 1'b1;
			done         = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_pop) begin
			cur_q <= desc;
			bcd_q <= '0;
			if ((desc.radix_code == RADIX_DEC) && !desc.wide) begin
				sh_q <= desc.mag << (VALUE_WIDTH - SHORT_WIDTH);
			end else begin
				sh_q <= desc.mag;
			end
		end else if (state_q == ST_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], sh_q[VALUE_WIDTH-1]};
			sh_q  <= sh_q << 1;
		end
		if (state_q == ST_SCAN) begin
			for (int i = 0; i < NDIG; i++) begin
				dig_q[i] <= nib[i];
			end
		end
		if (emit) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			sign_q    <= 1'b0;
			zero_q    <= 1'b0;
			x_q       <= 1'b0;
			dig_act_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (desc_pop) begin
						sign_q <= desc.neg;
						zero_q <= (desc.radix_code == RADIX_OCT) ||
						          (desc.radix_code == RADIX_HEX);
						x_q    <= (desc.radix_code == RADIX_HEX);
						cnt_q  <= desc.wide ? STEP_W'(VALUE_WIDTH) : STEP_W'(SHORT_WIDTH);
						priority if (desc.err) begin
							state_q <= ST_EMIT;
						end else if (desc.radix_code == RADIX_DEC) begin
							state_q <= ST_CONV;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == STEP_W'(1)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q     <= top;
					dig_act_q <= 1'b1;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						priority if (cur_q.err) begin
							dig_act_q <= 1'b0;
						end else if (sign_q) begin
							sign_q <= 1'b0;
						end else if (zero_q) begin
							zero_q <= 1'b0;
						end else if (x_q) begin
							x_q <= 1'b0;
						end else if (dig_act_q) begin
							if (idx_q == '0) begin
								dig_act_q <= 1'b0;
							end else begin
								idx_q <= idx_q - 1'b1;
							end
						end else begin
							dig_act_q <= 1'b0;
						end
						if (done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/integer_to_ascii_radix.sv
// Top level of the integer to ASCII converter: front, request queue and back.
`timescale 1ns / 1ps

// Converts one integer per item into ASCII text, one character per result
// item, most significant digit first, with last set on the final character.
// width_mode selects signed 32-bit, unsigned 32-bit or unsigned 64-bit (mode
// three behaves as 64-bit); radix_code selects binary, octal, decimal or
// hexadecimal. Negative signed values get a leading '-' (the most negative
// value prints exactly), octal gets a "0" prefix, hex gets "0x" and upper-case
// digits, binary gets a trailing 'b'. Binary with 64-bit width is rejected
// with a single result: char_out zero, last and error set. Items enter through
// a two-entry queue, so up to two requests are taken while an earlier number
// is still being printed. The back end handles one number at a time: it loads
// the request, runs a decimal one through the shift-add-3 converter one step
// per operand bit (32 in the 32-bit modes, 64 in 64-bit mode), collects the
// digits, then emits the characters (up to 34), one per cycle while pop keeps
// up. Results sit in one output register.
module integer_to_ascii_radix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  i2a_pkg::in_item_t    operand,
	output logic                 empty,
	input  logic                 pop,
	output i2a_pkg::out_item_t   result
);
	import i2a_pkg::*;

	desc_t front_desc;
	desc_t back_desc;
	logic  q_empty;
	logic  q_pop;

	// Classify the incoming item: sign, magnitude, rejected combinations.
	i2a_front u_front (
		.operand (operand),
		.desc    (front_desc)
	);

	// Hold classified items so the input side runs ahead of the printer.
	i2a_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_desc),
		.full   (full),
		.pop    (q_pop),
		.rdata  (back_desc),
		.empty  (q_empty)
	);

	// Extract digits and drive one character per accepted result.
	i2a_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc       (back_desc),
		.desc_empty (q_empty),
		.desc_pop   (q_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

### test/tb_top.sv
// Self-checking testbench for the integer to ASCII converter.
`timescale 1ns / 1ps

module tb_top;
	import i2a_pkg::*;

	// Width modes the package leaves unnamed: mode three behaves as 64-bit.
	localparam logic [1:0] MODE_U64   = 2'd2;
	localparam logic [1:0] MODE_ALIAS = 2'd3;

	// Cycles with no item moving on either side before the run is declared hung.
	// The worst honest gap is the receiver hold-off plus a 64-bit decimal conversion.
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 250;
	localparam int HOLD_TRIGGER = 300;
	localparam int DRAIN_CYCLES = 120;
	localparam int RANDOM_ITEMS = 135;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	logic      full;
	logic      empty;
	in_item_t  operand = '0;
	out_item_t result;

	in_item_t  pending_numbers[$];
	out_item_t expected_chars[$];
	int        numbers_taken = 0;
	int        chars_taken = 0;
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;

	integer_to_ascii_radix DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.operand (operand),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hold reset low at the start, release it on a rising edge.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Work out the text one number turns into and queue its characters.
	function automatic void predict_text(input in_item_t num);
		logic [63:0] mag;
		logic [63:0] radix;
		logic [63:0] rem;
		logic [31:0] low_word;
		logic [7:0]  text[$];
		logic [7:0]  digits[$];
		out_item_t   ch;
		// Binary has no room for 64-bit operands: one error item and nothing else.
		if (num.radix_code == RADIX_BIN && num.width_mode[1]) begin
			ch.char_out = CH_NUL;
			ch.last     = 1'b1;
			ch.error    = 1'b1;
			expected_chars.push_back(ch);
			return;
		end
		case (num.radix_code)
			RADIX_BIN: radix = 64'd2;
			RADIX_OCT: radix = 64'd8;
			RADIX_DEC: radix = 64'd10;
			default:   radix = 64'd16;
		endcase
		low_word = num.value[31:0];
		case (num.width_mode)
			MODE_S32: begin
				// Negate in 32 bits: the most negative value comes out as 2^31.
				if (low_word[31]) begin
					text.push_back(CH_MINUS);
					mag = {32'd0, 32'(-low_word)};
				end else begin
					mag = {32'd0, low_word};
				end
			end
			MODE_U32: mag = {32'd0, low_word};
			default: begin
				mag = num.value;
				if (VALUE_WIDTH < 64)
					mag &= (64'd1 << VALUE_WIDTH) - 64'd1;
			end
		endcase
		if (num.radix_code == RADIX_OCT || num.radix_code == RADIX_HEX)
			text.push_back(CH_ZERO);
		if (num.radix_code == RADIX_HEX)
			text.push_back(CH_X);
		// Peel digits off the low end; zero still yields one digit.
		do begin
			rem = mag % radix;
			if (rem >= 64'd10)
				digits.push_front(CH_UPPER + 8'(rem - 64'd10));
			else
				digits.push_front(CH_ZERO + 8'(rem));
			mag = mag / radix;
		end while (mag != 64'd0);
		foreach (digits[i])
			text.push_back(digits[i]);
		if (num.radix_code == RADIX_BIN)
			text.push_back(CH_B);
		foreach (text[k]) begin
			ch.char_out = text[k];
			ch.last     = (k == text.size() - 1);
			ch.error    = 1'b0;
			expected_chars.push_back(ch);
		end
	endfunction

	// Random pause for either side; suppressed for a stretch in the middle of the run.
	function automatic bit take_break();
		if (numbers_taken >= 70 && numbers_taken < 110)
			return 1'b0;
		return $urandom_range(0, 99) < 11;
	endfunction

	function automatic void add_number(input logic [63:0] value, input logic [1:0] mode,
			input logic [1:0] radix_code);
		in_item_t num;
		num.value      = value;
		num.width_mode = mode;
		num.radix_code = radix_code;
		pending_numbers.push_back(num);
	endfunction

	// Pick an operand shape: wide random, tiny, random length, or near a sign edge.
	function automatic logic [63:0] random_value();
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0: v = {$urandom, $urandom};
			1: v = 64'($urandom_range(0, 20));
			2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
			default: begin
				case ($urandom_range(0, 4))
					0: v = {$urandom, 32'h7FFF_FFFF};
					1: v = {$urandom, 32'h8000_0000};
					2: v = {$urandom, 32'hFFFF_FFFF};
					3: v = 64'hFFFF_FFFF_FFFF_FFFF;
					default: v = 64'h8000_0000_0000_0000;
				endcase
			end
		endcase
		return v;
	endfunction

	// Sender: present pending items, hold an item while the block is full.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push    <= 1'b0;
			operand <= '0;
		end else begin
			if (push && !full) begin
				predict_text(operand);
				numbers_taken++;
			end
			if (push && full) begin
				// hold the offered item until it is taken
			end else if (pending_numbers.size() > 0 && !take_break()) begin
				push    <= 1'b1;
				operand <= pending_numbers.pop_front();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver: check each character against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				chars_taken++;
				if (expected_chars.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected item char_out=%h last=%b error=%b",
						$time, result.char_out, result.last, result.error);
				end else begin
					out_item_t want;
					want = expected_chars.pop_front();
					if (result.char_out !== want.char_out) begin
						mismatches++;
						$display("%0t: char_out expected %h actual %h",
							$time, want.char_out, result.char_out);
					end
					if (result.last !== want.last) begin
						mismatches++;
						$display("%0t: last expected %b actual %b",
							$time, want.last, result.last);
					end
					if (result.error !== want.error) begin
						mismatches++;
						$display("%0t: error expected %b actual %b",
							$time, want.error, result.error);
					end
				end
			end
			// Stop draining once for a long stretch so the input side backs up.
			if (!hold_done && chars_taken >= HOLD_TRIGGER) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				pop       <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				pop       <= 1'b0;
			end else begin
				pop <= !take_break();
			end
		end
	end

	// Watchdog: give up when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [1:0] mode;
		// Zero in every width mode and radix, mode three included.
		for (int m = 0; m < 4; m++)
			for (int r = 0; r < 4; r++)
				add_number(64'd0, 2'(m), 2'(r));
		// Most negative 32-bit value, minus one, and the extremes of each width.
		add_number(64'h0000_0000_8000_0000, MODE_S32, RADIX_DEC);
		add_number(64'h0000_0000_8000_0000, MODE_S32, RADIX_HEX);
		add_number(64'h0000_0000_8000_0000, MODE_S32, RADIX_BIN);
		add_number(64'h0000_0000_FFFF_FFFF, MODE_S32, RADIX_DEC);
		add_number(64'hDEAD_BEEF_7FFF_FFFF, MODE_S32, RADIX_OCT);
		add_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_U32, RADIX_BIN);
		add_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_U64, RADIX_DEC);
		add_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_ALIAS, RADIX_OCT);
		add_number(64'h0123_4567_89AB_CDEF, MODE_U64, RADIX_HEX);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			mode = 2'($urandom_range(0, 3));
			add_number(random_value(), mode, 2'($urandom_range(0, 3)));
		end

		// Wait until every item is in, every character is out, then let things settle.
		while (pending_numbers.size() > 0 || push)
			@(posedge clk);
		while (expected_chars.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### integer_to_ascii_radix.f
rtl/i2a_pkg.sv
rtl/i2a_front.sv
rtl/i2a_fifo.sv
rtl/i2a_back.sv
rtl/integer_to_ascii_radix.sv
test/tb_top.sv
